// ===== rtl/prle_pkg.sv =====
package prle_pkg;

    // Longest run or literal group that one header may describe.
    localparam int MAX_GROUP = 32;

    // Width of the group counters, which must hold MAX_GROUP itself.
    localparam int CNT_W = $clog2(MAX_GROUP + 1);

    // Address width of the literal store.
    localparam int ADDR_W = (MAX_GROUP > 2) ? $clog2(MAX_GROUP) : 1;

    // Fixed codes of the PackBits format.
    localparam logic [7:0] END_MARKER = 8'd128;
    localparam logic [8:0] RUN_BASE   = 9'd257;

    // One input beat.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       is_last;
    } t_in;

    // One output beat.
    typedef struct packed {
        logic [7:0] code_byte;
        logic       end_of_stream;
    } t_out;

    // Controller states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_RUN_HDR,
        ST_RUN_DATA,
        ST_LIT_HDR,
        ST_LIT_DATA,
        ST_UPDATE,
        ST_TAIL,
        ST_END_MARK
    } t_state;

    // Source of the next output byte.
    typedef enum logic [2:0] {
        SRC_LIT_HDR,
        SRC_LIT_DATA,
        SRC_RUN_HDR,
        SRC_RUN_DATA,
        SRC_END
    } t_src;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic in_load;
        logic load_prev;
        logic run_inc;
        logic push;
        logic lc_clear;
        logic idx_start;
        logic idx_step;
        logic emit;
        t_src src;
        logic clear_all;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic have_prev;
        logic eq;
        logic run_lt_max;
        logic run_is1;
        logic run_ge2;
        logic lc_zero;
        logic lc_near_full;
        logic lit_done;
        logic last;
        logic out_free;
    } t_sts;

endpackage

// ===== rtl/packbits_run_length_encoder_unit.sv =====
// PackBits run-length encoder.
// Input channel: i_valid / o_stall with one raw byte and its last flag per beat.
// Output channel: o_valid / i_stall with one coded byte per beat; end_of_stream
// is set only on the end marker 128 that closes each stream.
// A run of two or more equal bytes becomes the header 257 - length and the byte;
// other bytes are gathered into literal groups, coded as count - 1 and the bytes.
// Both kinds of group are capped at MAX_GROUP bytes.
// One byte is in work at a time. Each accepted byte passes through the decide
// and tail states before the next byte is taken; a literal flush emits its
// header and its bytes, and a run inside the stream emits its header and its
// byte and then takes up the new byte in an update state. The closing flush
// after the last byte emits its own bytes and then the end marker. The
// controller sequences the output one byte per cycle, while the receiver does
// not stall, through a single read port on the literal store.
// Every output byte leaves through the output register.
// Reset clears the encoder state and empties the output register; the literal
// store is not cleared, as only entries already written are read back.
// While the receiver stalls, the output register holds its beat and the
// controller waits, and o_stall stays high until the item is complete.
module packbits_run_length_encoder_unit (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  prle_pkg::t_in  i_data,
    output logic           o_valid,
    input  logic           i_stall,
    output prle_pkg::t_out o_data
);

    prle_pkg::t_cmd cmd;
    prle_pkg::t_sts sts;

    // Sequencing of each byte's work.
    prle_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // Counters, literal store and output register.
    prle_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_data  (i_data),
        .i_stall (i_stall),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .o_valid (o_valid),
        .o_data  (o_data)
    );

endmodule

// ===== rtl/prle_dp.sv =====
module prle_dp (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  prle_pkg::t_in    i_data,
    input  logic             i_stall,
    input  prle_pkg::t_cmd   i_cmd,
    output prle_pkg::t_sts   o_sts,
    output logic             o_valid,
    output prle_pkg::t_out   o_data
);

    // Latched input beat.
    logic [7:0] r_b;
    logic       r_last;

    // Encoder state.
    logic [7:0]                  r_prev;
    logic                        r_have;
    logic [prle_pkg::CNT_W-1:0]  r_run;
    logic [prle_pkg::CNT_W-1:0]  r_lc;
    logic [prle_pkg::ADDR_W-1:0] r_idx;

    // Literal store with a registered read port.
    logic [7:0] r_mem [prle_pkg::MAX_GROUP];
    logic [7:0] r_rd_data;
    logic       rd_en;
    logic [prle_pkg::ADDR_W-1:0] rd_addr;

    // Output register.
    logic           r_o_valid;
    prle_pkg::t_out r_o_data;
    prle_pkg::t_out n_o_data;
    logic           out_free;

    // The output register can take a new byte when empty or being drained.
    assign out_free = !r_o_valid || !i_stall;

    // Input beat register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.in_load) begin
            r_b    <= i_data.data_byte;
            r_last <= i_data.is_last;
        end
    end

    // Previous byte, run length and literal count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear_all) begin
            r_prev <= '0;
            r_have <= 1'b0;
            r_run  <= '0;
            r_lc   <= '0;
        end else begin
            if (i_cmd.load_prev) begin
                r_prev <= r_b;
                r_have <= 1'b1;
                r_run  <= prle_pkg::CNT_W'(1);
            end else if (i_cmd.run_inc) begin
                r_run <= r_run + prle_pkg::CNT_W'(1);
            end
            if (i_cmd.push) begin
                r_lc <= r_lc + prle_pkg::CNT_W'(1);
            end else if (i_cmd.lc_clear) begin
                r_lc <= '0;
            end
        end
    end

    // Literal store write port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_mem[r_lc[prle_pkg::ADDR_W-1:0]] <= r_prev;
        end
    end

    // Read pointer: the read one ahead of the byte being emitted.
    assign rd_en   = i_cmd.idx_start || i_cmd.idx_step;
    assign rd_addr = i_cmd.idx_start ? '0 : r_idx + prle_pkg::ADDR_W'(1);

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.idx_start) begin
            r_idx <= '0;
        end else if (i_cmd.idx_step) begin
            r_idx <= r_idx + prle_pkg::ADDR_W'(1);
        end
    end

    // Output byte selection.
    always_comb begin
        n_o_data = '0;
        unique case (i_cmd.src)
            prle_pkg::SRC_LIT_HDR:  n_o_data.code_byte = 8'(r_lc - prle_pkg::CNT_W'(1));
            prle_pkg::SRC_LIT_DATA: n_o_data.code_byte = r_rd_data;
            prle_pkg::SRC_RUN_HDR:  n_o_data.code_byte =
                8'(prle_pkg::RUN_BASE - 9'(r_run));
            prle_pkg::SRC_RUN_DATA: n_o_data.code_byte = r_prev;
            prle_pkg::SRC_END: begin
                n_o_data.code_byte     = prle_pkg::END_MARKER;
                n_o_data.end_of_stream = 1'b1;
            end
            default:                n_o_data = '0;
        endcase
    end

    // Output register: holds its beat while the receiver stalls.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.emit && out_free) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit && out_free) begin
            r_o_data <= n_o_data;
        end
    end

    // Status towards the controller.
    always_comb begin
        o_sts.have_prev    = r_have;
        o_sts.eq           = (r_b == r_prev);
        o_sts.run_lt_max   = (r_run < prle_pkg::CNT_W'(prle_pkg::MAX_GROUP));
        o_sts.run_is1      = (r_run == prle_pkg::CNT_W'(1));
        o_sts.run_ge2      = (r_run >= prle_pkg::CNT_W'(2));
        o_sts.lc_zero      = (r_lc == '0);
        o_sts.lc_near_full = (r_lc == prle_pkg::CNT_W'(prle_pkg::MAX_GROUP - 1));
        o_sts.lit_done     = (prle_pkg::CNT_W'(r_idx) == r_lc - prle_pkg::CNT_W'(1));
        o_sts.last         = r_last;
        o_sts.out_free     = out_free;
    end

    assign o_valid = r_o_valid;
    assign o_data  = r_o_data;

endmodule

// ===== rtl/prle_ctrl.sv =====
module prle_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  prle_pkg::t_sts   i_sts,
    output prle_pkg::t_cmd   o_cmd
);

    prle_pkg::t_state r_state;
    prle_pkg::t_state n_state;
    logic             r_tail;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= prle_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // The tail flag marks the closing flush after the last byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tail <= 1'b0;
        end else if (r_state == prle_pkg::ST_TAIL && i_sts.last) begin
            r_tail <= 1'b1;
        end else if (r_state == prle_pkg::ST_END_MARK && i_sts.out_free) begin
            r_tail <= 1'b0;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            prle_pkg::ST_IDLE: begin
                if (i_valid) n_state = prle_pkg::ST_DECIDE;
            end
            prle_pkg::ST_DECIDE: begin
                priority if (!i_sts.have_prev) begin
                    n_state = prle_pkg::ST_TAIL;
                end else if (i_sts.eq && i_sts.run_lt_max) begin
                    n_state = (i_sts.run_is1 && !i_sts.lc_zero) ?
                              prle_pkg::ST_LIT_HDR : prle_pkg::ST_TAIL;
                end else if (i_sts.run_ge2) begin
                    n_state = prle_pkg::ST_RUN_HDR;
                end else begin
                    n_state = i_sts.lc_near_full ? prle_pkg::ST_LIT_HDR : prle_pkg::ST_TAIL;
                end
            end
            prle_pkg::ST_RUN_HDR: begin
                if (i_sts.out_free) n_state = prle_pkg::ST_RUN_DATA;
            end
            prle_pkg::ST_RUN_DATA: begin
                if (i_sts.out_free) begin
                    n_state = r_tail ? prle_pkg::ST_END_MARK : prle_pkg::ST_UPDATE;
                end
            end
            prle_pkg::ST_LIT_HDR: begin
                if (i_sts.out_free) n_state = prle_pkg::ST_LIT_DATA;
            end
            prle_pkg::ST_LIT_DATA: begin
                if (i_sts.out_free && i_sts.lit_done) begin
                    n_state = r_tail ? prle_pkg::ST_END_MARK : prle_pkg::ST_TAIL;
                end
            end
            prle_pkg::ST_UPDATE: begin
                n_state = prle_pkg::ST_TAIL;
            end
            prle_pkg::ST_TAIL: begin
                priority if (!i_sts.last) begin
                    n_state = prle_pkg::ST_IDLE;
                end else if (i_sts.run_ge2) begin
                    n_state = prle_pkg::ST_RUN_HDR;
                end else begin
                    n_state = prle_pkg::ST_LIT_HDR;
                end
            end
            prle_pkg::ST_END_MARK: begin
                if (i_sts.out_free) n_state = prle_pkg::ST_IDLE;
            end
            default: n_state = prle_pkg::ST_IDLE;
        endcase
    end

    // Commands to the datapath.
    always_comb begin
        o_cmd     = '0;
        o_cmd.src = prle_pkg::SRC_LIT_HDR;
        unique case (r_state)
            prle_pkg::ST_IDLE: begin
                o_cmd.in_load = i_valid;
            end
            prle_pkg::ST_DECIDE: begin
                priority if (!i_sts.have_prev) begin
                    o_cmd.load_prev = 1'b1;
                end else if (i_sts.eq && i_sts.run_lt_max) begin
                    o_cmd.run_inc = 1'b1;
                end else if (!i_sts.run_ge2) begin
                    o_cmd.push      = 1'b1;
                    o_cmd.load_prev = 1'b1;
                end else begin
                    o_cmd.push = 1'b0;
                end
            end
            prle_pkg::ST_RUN_HDR: begin
                o_cmd.emit = 1'b1;
                o_cmd.src  = prle_pkg::SRC_RUN_HDR;
            end
            prle_pkg::ST_RUN_DATA: begin
                o_cmd.emit = 1'b1;
                o_cmd.src  = prle_pkg::SRC_RUN_DATA;
            end
            prle_pkg::ST_LIT_HDR: begin
                o_cmd.emit      = 1'b1;
                o_cmd.src       = prle_pkg::SRC_LIT_HDR;
                o_cmd.idx_start = i_sts.out_free;
            end
            prle_pkg::ST_LIT_DATA: begin
                o_cmd.emit     = 1'b1;
                o_cmd.src      = prle_pkg::SRC_LIT_DATA;
                o_cmd.idx_step = i_sts.out_free;
                o_cmd.lc_clear = i_sts.out_free && i_sts.lit_done;
            end
            prle_pkg::ST_UPDATE: begin
                o_cmd.load_prev = 1'b1;
            end
            prle_pkg::ST_TAIL: begin
                o_cmd.push = i_sts.last && !i_sts.run_ge2;
            end
            prle_pkg::ST_END_MARK: begin
                o_cmd.emit      = 1'b1;
                o_cmd.src       = prle_pkg::SRC_END;
                o_cmd.clear_all = i_sts.out_free;
            end
            default: o_cmd = '0;
        endcase
    end

    // Input beats are taken only while idle.
    assign o_stall = (r_state != prle_pkg::ST_IDLE);

endmodule

// ===== rtl/prle_chk.sv =====
module prle_chk (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_valid,
    input logic           o_stall,
    input prle_pkg::t_in  i_data,
    input logic           o_valid,
    input logic           i_stall,
    input prle_pkg::t_out o_data
);

    // A stalled output beat stays put.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("output beat changed while stalled");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    // An accepted input beat keeps the block busy for the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input taken on consecutive cycles");

    // The end-of-stream flag only ever rides on the end marker.
    a_end_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.end_of_stream |-> o_data.code_byte == prle_pkg::END_MARKER)
        else $error("end of stream on a byte other than the end marker");

    // Reset leaves the block ready for input.
    a_ready_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_stall)
        else $error("input side busy after reset");

endmodule

bind packbits_run_length_encoder_unit prle_chk u_prle_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_stall (o_stall),
    .i_data  (i_data),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_data  (o_data)
);

// ===== tb/tb_packbits_run_length_encoder_unit.sv =====
`timescale 1ns / 100ps

module tb;

    localparam int HALF_PERIOD = 6;
    localparam int DRAIN_CYCLES = 20;
    localparam int EXP_DEPTH = 64;
    localparam int STREAM_MAX = 256;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    prle_pkg::t_in i_data = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    prle_pkg::t_out o_data;

    // Encoder state mirrored by the testbench.
    logic [7:0] lit_bytes [prle_pkg::MAX_GROUP];
    int lit_cnt = 0;
    int run_len = 0;
    logic [7:0] held_byte = 8'h00;
    bit held_valid = 1'b0;

    // Coded beats still to come out of the block, kept in a ring, oldest first.
    prle_pkg::t_out expected_codes [EXP_DEPTH];
    int exp_wr = 0;
    int exp_rd = 0;
    prle_pkg::t_out next_code;

    int fault_count = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    packbits_run_length_encoder_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    // Encoder prediction.
    function automatic void queue_code(input logic [7:0] code, input logic eos);
        prle_pkg::t_out beat;
        beat.code_byte = code;
        beat.end_of_stream = eos;
        expected_codes[exp_wr % EXP_DEPTH] = beat;
        exp_wr++;
    endfunction

    function automatic void flush_literals();
        logic [7:0] hdr;
        if (lit_cnt == 0)
            return;
        hdr = 8'(lit_cnt - 1);
        queue_code(hdr, 1'b0);
        for (int i = 0; i < lit_cnt; i++)
            queue_code(lit_bytes[i], 1'b0);
        lit_cnt = 0;
    endfunction

    function automatic void emit_run();
        logic [7:0] hdr;
        hdr = 8'(int'(prle_pkg::RUN_BASE) - run_len);
        queue_code(hdr, 1'b0);
        queue_code(held_byte, 1'b0);
    endfunction

    // The held byte joins the literal group, which goes out once it is full.
    function automatic void push_literal();
        if (lit_cnt < prle_pkg::MAX_GROUP)
            lit_bytes[lit_cnt] = held_byte;
        lit_cnt++;
        if (lit_cnt >= prle_pkg::MAX_GROUP)
            flush_literals();
    endfunction

    function automatic void encode_byte(input prle_pkg::t_in beat);
        if (!held_valid) begin
            held_byte = beat.data_byte;
            run_len = 1;
            held_valid = 1'b1;
        end else if (beat.data_byte == held_byte && run_len < prle_pkg::MAX_GROUP) begin
            run_len++;
            // A starting run pushes out the literals gathered ahead of it.
            if (run_len == 2)
                flush_literals();
        end else begin
            if (run_len >= 2)
                emit_run();
            else
                push_literal();
            held_byte = beat.data_byte;
            run_len = 1;
        end

        // The last byte flushes everything and closes the stream.
        if (beat.is_last) begin
            if (run_len >= 2) begin
                emit_run();
            end else begin
                push_literal();
                flush_literals();
            end
            queue_code(prle_pkg::END_MARKER, 1'b1);
            lit_cnt = 0;
            run_len = 0;
            held_byte = 8'h00;
            held_valid = 1'b0;
        end
    endfunction

    // Sends one raw byte and waits until the block takes the beat.
    task automatic send_byte(input logic [7:0] value, input logic last_flag);
        prle_pkg::t_in beat;
        beat.data_byte = value;
        beat.is_last = last_flag;
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= beat;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        encode_byte(beat);
    endtask

    task automatic release_inputs();
        @(negedge i_clk);
        i_valid <= 1'b0;
    endtask

    // Receiver stalls at random.
    always @(negedge i_clk)
        i_stall <= ($urandom_range(99) < recv_stall_pct);

    // Each coded beat taken from the block is checked against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (exp_wr == exp_rd) begin
                fault_count++;
                $display("%0t: unexpected beat, expected none, got code %0d eos %0b",
                         $time, o_data.code_byte, o_data.end_of_stream);
            end else begin
                next_code = expected_codes[exp_rd % EXP_DEPTH];
                exp_rd++;
                if (o_data.code_byte !== next_code.code_byte ||
                    o_data.end_of_stream !== next_code.end_of_stream) begin
                    fault_count++;
                    $display("%0t: beat mismatch, expected code %0d eos %0b, got code %0d eos %0b",
                             $time, next_code.code_byte, next_code.end_of_stream,
                             o_data.code_byte, o_data.end_of_stream);
                end
            end
        end
    end

    // Streams of a single byte, at both ends of the byte range and in the middle.
    task automatic test_single_byte_streams();
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h80, 1'b1);
        release_inputs();
    endtask

    // Short runs and literal groups in every order, each stream closed by its last byte.
    task automatic test_runs_and_literals();
        // A pair that ends the stream.
        send_byte(8'hAA, 1'b0);
        send_byte(8'hAA, 1'b1);
        // Literals that must go out before the run that follows them.
        send_byte(8'h01, 1'b0);
        send_byte(8'h02, 1'b0);
        send_byte(8'h03, 1'b0);
        send_byte(8'h03, 1'b0);
        send_byte(8'h03, 1'b1);
        // A run followed by a single trailing byte.
        send_byte(8'h05, 1'b0);
        send_byte(8'h05, 1'b0);
        send_byte(8'h06, 1'b1);
        // Two literals at the end of the stream.
        send_byte(8'h07, 1'b0);
        send_byte(8'h08, 1'b1);
        // Run after run.
        send_byte(8'h09, 1'b0);
        send_byte(8'h09, 1'b0);
        send_byte(8'h09, 1'b0);
        send_byte(8'h04, 1'b0);
        send_byte(8'h04, 1'b1);
        // Top byte run, then a zero byte on its own.
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);
        release_inputs();
    endtask

    // Random streams built from runs, literal stretches and noise from a small
    // alphabet; long runs and long literal stretches reach the group cap.
    task automatic test_random_streams(input int n_items);
        logic [7:0] stream_bytes [STREAM_MAX];
        int stream_len;
        logic [7:0] b;
        int target;
        int seg_len;
        int kind;
        int sent;
        sent = 0;
        while (sent < n_items) begin
            stream_len = 0;
            target = ($urandom_range(9) == 0) ? $urandom_range(60, 110)
                                              : $urandom_range(1, 40);
            // The last stream of the phase is cut to the items still owed.
            if (target > n_items - sent)
                target = n_items - sent;
            while (stream_len < target) begin
                kind = $urandom_range(9);
                if (kind < 4) begin
                    seg_len = ($urandom_range(2) == 0)
                              ? $urandom_range(prle_pkg::MAX_GROUP - 1,
                                               2 * prle_pkg::MAX_GROUP + 2)
                              : $urandom_range(2, 6);
                    b = 8'($urandom_range(255));
                    repeat (seg_len) begin
                        stream_bytes[stream_len] = b;
                        stream_len++;
                    end
                end else if (kind < 8) begin
                    seg_len = ($urandom_range(3) == 0)
                              ? $urandom_range(prle_pkg::MAX_GROUP - 1,
                                               prle_pkg::MAX_GROUP + 3)
                              : $urandom_range(1, 8);
                    // Each literal differs from the byte before it.
                    b = (stream_len != 0) ? stream_bytes[stream_len - 1]
                                          : 8'($urandom_range(255));
                    repeat (seg_len) begin
                        b = 8'(b + $urandom_range(1, 255));
                        stream_bytes[stream_len] = b;
                        stream_len++;
                    end
                end else begin
                    repeat ($urandom_range(1, 10)) begin
                        b = 8'($urandom_range(3));
                        stream_bytes[stream_len] = b;
                        stream_len++;
                    end
                end
            end
            if (stream_len > target)
                stream_len = target;
            for (int i = 0; i < stream_len; i++)
                send_byte(stream_bytes[i], i == stream_len - 1);
            sent += stream_len;
        end
        release_inputs();
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_single_byte_streams();
        test_runs_and_literals();

        send_idle_pct = 0;
        recv_stall_pct = 0;
        test_random_streams(109);

        send_idle_pct = 73;
        recv_stall_pct = 0;
        test_random_streams(109);

        send_idle_pct = 0;
        recv_stall_pct = 73;
        test_random_streams(109);

        send_idle_pct = 18;
        recv_stall_pct = 18;
        test_random_streams(109);

        // Let the last beats drain, then keep watching for stray beats.
        while (exp_wr != exp_rd)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fault_count == 0 && exp_wr == exp_rd) begin
            $display("[packbits_run_length_encoder_unit] OK");
        end else begin
            $display("[packbits_run_length_encoder_unit] ERROR");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #5_000_000;
        $display("%0t: timeout with %0d beats outstanding", $time, exp_wr - exp_rd);
        $display("[packbits_run_length_encoder_unit] ERROR");
        $finish;
    end

endmodule
